### hdl/saes_pkg.sv
// S-AES package: nibble S-boxes, GF(16) arithmetic, round functions and key expansion.
// Self-contained; imported by saes_block_cipher_core.
`default_nettype none

package saes_pkg;

   localparam int BLOCK_W = 16;
   localparam int KEY_W   = 16;

   // Configuration register indexes
   localparam logic CSR_CIPHER_KEY   = 1'b0;
   localparam logic CSR_DECRYPT_MODE = 1'b1;

   // Key schedule round constants
   localparam logic [7:0] RCON1 = 8'h80;
   localparam logic [7:0] RCON2 = 8'h30;

   // MixColumns coefficients
   localparam logic [3:0] MIX_FWD_DIAG = 4'h1;
   localparam logic [3:0] MIX_FWD_OFF  = 4'h4;
   localparam logic [3:0] MIX_INV_DIAG = 4'h9;
   localparam logic [3:0] MIX_INV_OFF  = 4'h2;

   typedef struct packed {
      logic [BLOCK_W-1:0] k1;
      logic [BLOCK_W-1:0] k2;
   } round_keys_type;

   function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'h9;  4'h1: r = 4'h4;  4'h2: r = 4'hA;  4'h3: r = 4'hB;
         4'h4: r = 4'hD;  4'h5: r = 4'h1;  4'h6: r = 4'h8;  4'h7: r = 4'h5;
         4'h8: r = 4'h6;  4'h9: r = 4'h2;  4'hA: r = 4'h0;  4'hB: r = 4'h3;
         4'hC: r = 4'hC;  4'hD: r = 4'hE;  4'hE: r = 4'hF;  default: r = 4'h7;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] sbox_inv(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'hA;  4'h1: r = 4'h5;  4'h2: r = 4'h9;  4'h3: r = 4'hB;
         4'h4: r = 4'h1;  4'h5: r = 4'h7;  4'h6: r = 4'h8;  4'h7: r = 4'hF;
         4'h8: r = 4'h6;  4'h9: r = 4'h0;  4'hA: r = 4'h2;  4'hB: r = 4'h3;
         4'hC: r = 4'hC;  4'hD: r = 4'h4;  4'hE: r = 4'hD;  default: r = 4'hE;
      endcase
      return r;
   endfunction

   // GF(16) multiply, modulus x^4+x+1
   function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] aa;
      logic [3:0] r;
      aa = {1'b0, a};
      r  = 4'h0;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            r = r ^ aa[3:0];
         end
         aa = {aa[3:0], 1'b0};
         if (aa[4]) begin
            aa = aa ^ 5'h13;
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] sub_word(input logic [15:0] v, input logic inv);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = inv ? sbox_inv(v[4*i +: 4]) : sbox_fwd(v[4*i +: 4]);
      end
      return r;
   endfunction

   // Swap the two nibbles of the bottom row
   function automatic logic [15:0] swap_rows(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [15:0] mix_cols(input logic [15:0] v,
                                            input logic [3:0] diag,
                                            input logic [3:0] off);
      logic [3:0] m0, m1, m2, m3;
      m0 = gf16_mul(diag, v[15:12]) ^ gf16_mul(off, v[11:8]);
      m1 = gf16_mul(off, v[15:12])  ^ gf16_mul(diag, v[11:8]);
      m2 = gf16_mul(diag, v[7:4])   ^ gf16_mul(off, v[3:0]);
      m3 = gf16_mul(off, v[7:4])    ^ gf16_mul(diag, v[3:0]);
      return {m0, m1, m2, m3};
   endfunction

   // RotNib then SubNib on one key word
   function automatic logic [7:0] key_g(input logic [7:0] w);
      return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])};
   endfunction

   function automatic round_keys_type expand_key(input logic [KEY_W-1:0] key);
      round_keys_type rk;
      logic [7:0] w0, w1, w2, w3, w4, w5;
      w0 = key[15:8];
      w1 = key[7:0];
      w2 = w0 ^ RCON1 ^ key_g(w1);
      w3 = w2 ^ w1;
      w4 = w2 ^ RCON2 ^ key_g(w3);
      w5 = w4 ^ w3;
      rk.k1 = {w2, w3};
      rk.k2 = {w4, w5};
      return rk;
   endfunction

   // Round keys of the all-zero reset key
   localparam round_keys_type RK_RESET = expand_key({KEY_W{1'b0}});

endpackage

`default_nettype wire

### hdl/saes_block_cipher_core.sv
// S-AES block cipher core: registered single-pass encrypt/decrypt datapath.
// Depends on saes_pkg for the S-boxes, round functions and key expansion.
//
// Usage
//   Request: a 16-bit block on req_block_in is taken at each rising edge where
//   start is high and busy is low. busy is always low: one block per cycle.
//   Response: rsp_block_out is valid for exactly one cycle, marked by
//   rsp_strobe, once the request has passed the input register and then the
//   result register. Results leave in request order.
//   Throughput: one block per clock, set by the two-stage register pipeline;
//   both rounds sit in the logic between the input and result registers.
//   The receiver cannot stall, so nothing is ever held back.
//   Configuration: csr_index 0 = cipher key (16 bits), 1 = decrypt mode
//   (csr_wdata[0]). csr_ready is always high; a transfer completes when
//   csr_valid is high. The round keys are expanded at the key write, so a block
//   may follow the write in the very next cycle. Write only while idle.
//   Reset (synchronous, active high): pipeline emptied, key = 0, encrypt mode,
//   round keys set to those of the zero key.
`default_nettype none

module saes_block_cipher_core
   import saes_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [BLOCK_W-1:0] req_block_in,
   // response
   output      logic               rsp_strobe,
   output      logic [BLOCK_W-1:0] rsp_block_out,
   // configuration
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic               csr_index,
   input  wire logic [KEY_W-1:0]   csr_wdata
);

   // Configuration: round keys held pre-expanded
   logic [KEY_W-1:0]   k0_ff;
   round_keys_type     rk_ff;
   logic               decrypt_ff;

   // Pipeline
   logic               in_vld_ff;
   logic [BLOCK_W-1:0] in_blk_ff;
   logic               out_vld_ff;
   logic [BLOCK_W-1:0] out_blk_ff;
   logic [BLOCK_W-1:0] out_blk_in;

   logic               req_xfer;
   logic               csr_xfer;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_xfer  = start & ~busy;
   assign csr_xfer  = csr_valid & csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff      <= '0;
         rk_ff      <= RK_RESET;
         decrypt_ff <= 1'b0;
      end else if (csr_xfer) begin
         unique case (csr_index)
            CSR_CIPHER_KEY: begin
               k0_ff <= csr_wdata;
               rk_ff <= expand_key(csr_wdata);
            end
            CSR_DECRYPT_MODE: begin
               decrypt_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Both rounds in one pass
   always_comb begin
      logic [BLOCK_W-1:0] t;
      if (!decrypt_ff) begin
         t = in_blk_ff ^ k0_ff;
         t = mix_cols(swap_rows(sub_word(t, 1'b0)), MIX_FWD_DIAG, MIX_FWD_OFF) ^ rk_ff.k1;
         t = swap_rows(sub_word(t, 1'b0)) ^ rk_ff.k2;
      end else begin
         t = in_blk_ff ^ rk_ff.k2;
         t = sub_word(swap_rows(t), 1'b1) ^ rk_ff.k1;
         t = mix_cols(t, MIX_INV_DIAG, MIX_INV_OFF);
         t = sub_word(swap_rows(t), 1'b1) ^ k0_ff;
      end
      out_blk_in = t;
   end

   // Control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= req_xfer;
         out_vld_ff <= in_vld_ff;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_blk_ff <= req_block_in;
      end
      if (in_vld_ff) begin
         out_blk_ff <= out_blk_in;
      end
   end

   assign rsp_strobe    = out_vld_ff;
   assign rsp_block_out = out_blk_ff;

endmodule

`default_nettype wire

### verif/tb_saes_block_cipher_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for saes_block_cipher_core: directed and random blocks in both
// directions under many keys, checked against an S-AES predictor held in the bench.
// Depends on saes_pkg (widths, register indexes, round constants) and the core itself.

module tb_saes_block_cipher_core;
   import saes_pkg::*;

   // Worst case is roughly 730 blocks each behind the longest idle gap; this is several times that.
   localparam int CYCLE_LIMIT  = 200000;
   // Request register plus result register, with some slack.
   localparam int DRAIN_CYCLES = 4;

   // Nibble S-boxes packed as 16 nibbles, entry n at bits 4n+3..4n.
   localparam logic [63:0] SBOX_ENC = 64'h7FEC_3026_581D_BA49;
   localparam logic [63:0] SBOX_DEC = 64'hED4C_3206_F871_B95A;

   typedef enum logic {MODE_ENCRYPT = 1'b0, MODE_DECRYPT = 1'b1} cipher_mode_type;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               start        = 1'b0;
   logic [BLOCK_W-1:0] req_block_in = '0;
   logic               csr_valid    = 1'b0;
   logic               csr_index    = CSR_CIPHER_KEY;
   logic [KEY_W-1:0]   csr_wdata    = '0;
   wire                busy;
   wire                rsp_strobe;
   wire [BLOCK_W-1:0]  rsp_block_out;
   wire                csr_ready;

   // Bench copy of the configuration, updated on each register transfer.
   logic [KEY_W-1:0]   key_shadow  = '0;
   cipher_mode_type    mode_shadow = MODE_ENCRYPT;

   // Blocks the core still owes us, oldest first.
   logic [BLOCK_W-1:0] cipher_out_q[$];

   int error_count    = 0;
   int blocks_checked = 0;
   int settings_used  = 1;
   int cycle_count    = 0;
   bit no_idle        = 1'b0;

   saes_block_cipher_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_block_in  (req_block_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_block_out (rsp_block_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // GF(16) product, reduction by x^4 = x + 1.
   function automatic logic [3:0] gf_mult(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      logic [3:0] x;
      acc = '0;
      x   = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            acc ^= x;
         end
         x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic logic [3:0] box_lookup(input logic [63:0] box, input logic [3:0] n);
      return box[4*int'(n) +: 4];
   endfunction

   function automatic logic [15:0] nibble_sub(input logic [15:0] v, input logic [63:0] box);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = box_lookup(box, v[4*i +: 4]);
      end
      return r;
   endfunction

   // Bottom row of the 2x2 state is n1/n3; swap those two.
   function automatic logic [15:0] row_shift(input logic [15:0] v);
      logic [15:0] r;
      r       = v;
      r[11:8] = v[3:0];
      r[3:0]  = v[11:8];
      return r;
   endfunction

   function automatic logic [15:0] column_mix(input logic [15:0] v, input logic [3:0] diag,
                                              input logic [3:0] off);
      logic [15:0] r;
      logic [3:0]  top;
      logic [3:0]  bot;
      for (int c = 0; c < 2; c++) begin
         top              = v[8*c+4 +: 4];
         bot              = v[8*c +: 4];
         r[8*c+4 +: 4]    = gf_mult(diag, top) ^ gf_mult(off, bot);
         r[8*c +: 4]      = gf_mult(off, top) ^ gf_mult(diag, bot);
      end
      return r;
   endfunction

   // Key schedule g(): rotate the two nibbles, then substitute each.
   function automatic logic [7:0] key_word_func(input logic [7:0] w);
      return {box_lookup(SBOX_ENC, w[3:0]), box_lookup(SBOX_ENC, w[7:4])};
   endfunction

   function automatic logic [15:0] saes_transform(input logic [15:0] blk,
                                                  input logic [15:0] key,
                                                  input cipher_mode_type mode);
      logic [7:0]  w2, w3, w4, w5;
      logic [15:0] k1, k2, s;
      w2 = key[15:8] ^ RCON1 ^ key_word_func(key[7:0]);
      w3 = w2 ^ key[7:0];
      w4 = w2 ^ RCON2 ^ key_word_func(w3);
      w5 = w4 ^ w3;
      k1 = {w2, w3};
      k2 = {w4, w5};
      if (mode == MODE_ENCRYPT) begin
         s = nibble_sub(blk ^ key, SBOX_ENC);
         s = column_mix(row_shift(s), MIX_FWD_DIAG, MIX_FWD_OFF) ^ k1;
         s = row_shift(nibble_sub(s, SBOX_ENC)) ^ k2;
      end else begin
         s = nibble_sub(row_shift(blk ^ k2), SBOX_DEC) ^ k1;
         s = column_mix(s, MIX_INV_DIAG, MIX_INV_OFF);
         s = nibble_sub(row_shift(s), SBOX_DEC) ^ key;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Leaves start high so back-to-back blocks never drop it within one time step.
   task automatic send_block(input logic [BLOCK_W-1:0] blk);
      start        <= 1'b1;
      req_block_in <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
      cipher_out_q.push_back(saes_transform(blk, key_shadow, mode_shadow));
   endtask

   // Mostly no gap, some short ones, the odd long one.
   task automatic idle_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 50) begin
         n = 0;
      end else if (pick < 90) begin
         n = $urandom_range(1, 3);
      end else begin
         n = $urandom_range(8, 40);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drops start and waits until every outstanding block is back; always moves time on,
   // so a following raise of start lands in a later step.
   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (cipher_out_q.size() != 0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Register side (only used with the pipeline empty)
   // ---------------------------------------------------------------------------------------

   task automatic write_reg(input logic idx, input logic [KEY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CIPHER_KEY) begin
         key_shadow = data;
      end else begin
         // only bit 0 of the mode word is kept
         mode_shadow = cipher_mode_type'(data[0]);
      end
   endtask

   task automatic program_regs(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] mode_word);
      write_reg(CSR_CIPHER_KEY, key);
      write_reg(CSR_DECRYPT_MODE, mode_word);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Result checking: the core cannot be stalled, so each strobe is one transfer.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      logic [BLOCK_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (cipher_out_q.size() == 0) begin
            $error("block_out: expected no transfer, got %h", rsp_block_out);
            error_count++;
         end else begin
            want = cipher_out_q.pop_front();
            blocks_checked++;
            if (rsp_block_out !== want) begin
               $error("block_out: expected %h, got %h", want, rsp_block_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d blocks outstanding",
                  cycle_count, cipher_out_q.size());
         $display("tb_saes_block_cipher_core: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Straight out of reset: key 0, encrypt.
   task automatic test_reset_state();
      send_block(16'h0000);
      send_block(16'hFFFF);
      wait_all_results();
   endtask

   // Textbook S-AES pair, both directions.
   task automatic test_known_vector();
      program_regs(16'h4AF5, {15'h0, MODE_ENCRYPT});
      send_block(16'hD728);
      wait_all_results();
      program_regs(16'h4AF5, {15'h0, MODE_DECRYPT});
      send_block(16'h24EC);
      wait_all_results();
   endtask

   // All-zero and all-one keys and blocks in both directions.
   task automatic test_extremes();
      logic [KEY_W-1:0] key;
      for (int k = 0; k < 2; k++) begin
         for (int m = 0; m < 2; m++) begin
            key = (k == 0) ? 16'h0000 : 16'hFFFF;
            program_regs(key, (m == 0) ? {15'h0, MODE_ENCRYPT} : {15'h0, MODE_DECRYPT});
            send_block(16'h0000);
            send_block(16'hFFFF);
            wait_all_results();
         end
      end
   endtask

   // Mode word with junk above bit 0: the upper bits must be dropped.
   task automatic test_mode_width();
      program_regs(16'hA5C3, 16'hFFFE);
      send_block(16'h1234);
      send_block(16'hEDCB);
      wait_all_results();
      program_regs(16'hA5C3, 16'h8001);
      send_block(16'h1234);
      send_block(16'hEDCB);
      wait_all_results();
   endtask

   // Random keys and blocks; the direction alternates per phase, phase 1 runs without gaps
   // and phase 3 drains the pipeline half way through.
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [KEY_W-1:0]   key;
      logic [KEY_W-1:0]   mode_word;
      logic [BLOCK_W-1:0] blk;
      int                 pick;
      for (int p = 0; p < phases; p++) begin
         pick = $urandom_range(0, 9);
         key  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
         mode_word    = 16'($urandom);
         mode_word[0] = p[0];
         program_regs(key, mode_word);
         no_idle = (p == 1);
         for (int i = 0; i < per_phase; i++) begin
            if (p == 3 && i == per_phase / 2) begin
               wait_all_results();
            end
            pick = $urandom_range(0, 19);
            blk  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            send_block(blk);
            idle_gap();
         end
         wait_all_results();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_known_vector();
      test_extremes();
      test_mode_width();
      test_random_traffic(14, 50);

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d blocks checked across %0d key/direction settings", blocks_checked,
               settings_used);
      $display("covered reset defaults, the textbook pair, extreme keys and mode-word masking");
      if (error_count == 0) begin
         $display("tb_saes_block_cipher_core: clean");
      end else begin
         $display("tb_saes_block_cipher_core: errors");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/saes_pkg.sv
hdl/saes_block_cipher_core.sv
verif/tb_saes_block_cipher_core.sv
